@@ sv/lph_pkg.sv @@
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int TableSlots = 1024;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int CountW     = 10;

  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_PUT = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        key_low;
    logic [31:0]        key_high;
    logic signed [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [63:0] value_out;
    logic [1:0]         status;
    logic [9:0]         entry_count;
    logic [31:0]        collision_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_FIND_CHK,
    S_PLACE,
    S_PLACE_CHK,
    S_SCAN,
    S_SCAN_CHK,
    S_OUT
  } state_t;

  // memory port request from control to store
  typedef struct packed {
    logic             rd;
    logic [SlotW-1:0] raddr;
    logic             wr;
    logic [SlotW-1:0] waddr;
    logic [63:0]      wkey;
    logic [63:0]      wval;
    logic             wval_en;
  } mem_req_t;

endpackage

@@ sv/lph_store.sv @@
// ----------------------------------------------------------------------------
// lph_store
// Key and value memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lph_store (
  input  logic               clk,
  input  lph_pkg::mem_req_t  mreq,
  output logic [63:0]        rkey,
  output logic [63:0]        rval
);

  logic [63:0] key_mem [lph_pkg::TableSlots];
  logic [63:0] val_mem [lph_pkg::TableSlots];

  always_ff @(posedge clk) begin
    if (mreq.wr) begin
      key_mem[mreq.waddr] <= mreq.wkey;
    end
    if (mreq.rd) begin
      rkey <= key_mem[mreq.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.wr && mreq.wval_en) begin
      val_mem[mreq.waddr] <= mreq.wval;
    end
    if (mreq.rd) begin
      rval <= val_mem[mreq.raddr];
    end
  end

endmodule

@@ sv/lph_ctrl.sv @@
// ----------------------------------------------------------------------------
// lph_ctrl
// Probe sequencer: lookup, insert, delete with cluster re-placement.
// ----------------------------------------------------------------------------
module lph_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lph_pkg::req_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lph_pkg::rsp_t      out_data,
  output lph_pkg::mem_req_t  mreq,
  input  logic [63:0]        rkey,
  input  logic [63:0]        rval
);

  localparam int SlotW = lph_pkg::SlotW;
  localparam logic [SlotW-1:0] SlotOne = SlotW'(1);
  localparam logic [lph_pkg::CountW-1:0] HalfLoad =
    lph_pkg::CountW'(lph_pkg::TableSlots / 2);

  lph_pkg::state_t state_r, state_nxt;

  logic [SlotW-1:0]  clr_r, clr_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [63:0]       key_r, key_nxt;
  logic [63:0]       val_r, val_nxt;
  logic [SlotW-1:0]  pos_r, pos_nxt;
  logic [SlotW-1:0]  home_r, home_nxt;
  logic [SlotW-1:0]  scan_r, scan_nxt;
  logic [lph_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [31:0]       col_r, col_nxt;
  lph_pkg::rsp_t     rsp_r, rsp_nxt;

  logic in_fire;
  logic [63:0] in_key;

  assign in_key  = {in_data.key_high, in_data.key_low};
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lph_pkg::S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    home_r <= home_nxt;
    scan_r <= scan_nxt;
    rsp_r  <= rsp_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lph_pkg::S_CLEAR: begin
        if (clr_r == '1) state_nxt = lph_pkg::S_IDLE;
      end
      lph_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data.req_type == lph_pkg::REQ_NOP || in_key == '0) state_nxt = lph_pkg::S_OUT;
          else state_nxt = lph_pkg::S_FIND_CHK;
        end
      end
      lph_pkg::S_FIND: state_nxt = lph_pkg::S_FIND_CHK;
      lph_pkg::S_FIND_CHK: begin
        if (rkey == key_r) begin
          state_nxt = (req_r == lph_pkg::REQ_DEL) ? lph_pkg::S_SCAN_CHK : lph_pkg::S_OUT;
        end else if (rkey == '0) begin
          state_nxt = lph_pkg::S_OUT;
        end else begin
          state_nxt = lph_pkg::S_FIND_CHK;
        end
      end
      lph_pkg::S_SCAN_CHK: begin
        // an entry sitting on its home slot re-reads it after the clear lands
        if (rkey == '0) state_nxt = lph_pkg::S_OUT;
        else if (rkey[SlotW-1:0] == scan_r) state_nxt = lph_pkg::S_PLACE;
        else state_nxt = lph_pkg::S_PLACE_CHK;
      end
      lph_pkg::S_PLACE_CHK: begin
        if (rkey == '0) state_nxt = lph_pkg::S_SCAN;
      end
      lph_pkg::S_SCAN: state_nxt = lph_pkg::S_SCAN_CHK;
      lph_pkg::S_PLACE: state_nxt = lph_pkg::S_PLACE_CHK;
      lph_pkg::S_OUT: begin
        if (out_ready) state_nxt = lph_pkg::S_IDLE;
      end
      default: state_nxt = lph_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt  = clr_r;
    req_nxt  = req_r;
    key_nxt  = key_r;
    val_nxt  = val_r;
    pos_nxt  = pos_r;
    home_nxt = home_r;
    scan_nxt = scan_r;
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    rsp_nxt  = rsp_r;
    mreq     = '0;
    case (state_r)
      lph_pkg::S_CLEAR: begin
        mreq.wr    = 1'b1;
        mreq.waddr = clr_r;
        mreq.wkey  = '0;
        clr_nxt    = clr_r + SlotOne;
      end
      lph_pkg::S_IDLE: begin
        req_nxt  = in_data.req_type;
        key_nxt  = in_key;
        val_nxt  = in_data.value_in;
        pos_nxt  = in_data.key_low[SlotW-1:0];
        home_nxt = in_data.key_low[SlotW-1:0];
        rsp_nxt  = '0;
        rsp_nxt.entry_count     = cnt_r;
        rsp_nxt.collision_count = col_r;
        if (in_data.req_type != lph_pkg::REQ_NOP && in_key == '0) begin
          rsp_nxt.status = lph_pkg::ST_ZERO;
        end
        mreq.rd    = in_fire;
        mreq.raddr = in_data.key_low[SlotW-1:0];
      end
      lph_pkg::S_FIND_CHK: begin
        if (rkey == key_r) begin
          rsp_nxt.hit = 1'b1;
          if (req_r == lph_pkg::REQ_GET) rsp_nxt.value_out = rval;
          else if (req_r == lph_pkg::REQ_PUT) begin
            mreq.wr = 1'b1; mreq.waddr = pos_r; mreq.wkey = key_r;
            mreq.wval = val_r; mreq.wval_en = 1'b1;
          end else begin
            mreq.wr = 1'b1; mreq.waddr = pos_r; mreq.wkey = '0;
            cnt_nxt = cnt_r - 1'b1;
            rsp_nxt.entry_count = cnt_r - 1'b1;
            scan_nxt   = pos_r + SlotOne;
            mreq.rd    = 1'b1;
            mreq.raddr = pos_r + SlotOne;
          end
        end else if (rkey == '0) begin
          if (req_r == lph_pkg::REQ_PUT) begin
            if (cnt_r >= HalfLoad) rsp_nxt.status = lph_pkg::ST_FULL;
            else begin
              mreq.wr = 1'b1; mreq.waddr = pos_r; mreq.wkey = key_r;
              mreq.wval = val_r; mreq.wval_en = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              rsp_nxt.entry_count = cnt_r + 1'b1;
              if (pos_r != home_r && col_r != '1) begin
                col_nxt = col_r + 1'b1;
                rsp_nxt.collision_count = col_r + 1'b1;
              end
            end
          end else begin
            rsp_nxt.status = lph_pkg::ST_MISS;
          end
        end else begin
          pos_nxt    = pos_r + SlotOne;
          mreq.rd    = 1'b1;
          mreq.raddr = pos_r + SlotOne;
        end
      end
      lph_pkg::S_SCAN_CHK: begin
        // rkey/rval hold the entry at scan_r
        if (rkey != '0) begin
          key_nxt  = rkey;
          val_nxt  = rval;
          home_nxt = rkey[SlotW-1:0];
          pos_nxt  = rkey[SlotW-1:0];
          mreq.wr = 1'b1; mreq.waddr = scan_r; mreq.wkey = '0;
          cnt_nxt = cnt_r - 1'b1;
          mreq.rd    = (rkey[SlotW-1:0] != scan_r);
          mreq.raddr = rkey[SlotW-1:0];
        end
      end
      lph_pkg::S_PLACE_CHK: begin
        if (rkey == '0) begin
          mreq.wr = 1'b1; mreq.waddr = pos_r; mreq.wkey = key_r;
          mreq.wval = val_r; mreq.wval_en = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rsp_nxt.entry_count = cnt_r + 1'b1;
          if (pos_r != home_r && col_r != '1) begin
            col_nxt = col_r + 1'b1;
            rsp_nxt.collision_count = col_r + 1'b1;
          end
          scan_nxt = scan_r + SlotOne;
        end else begin
          pos_nxt    = pos_r + SlotOne;
          mreq.rd    = 1'b1;
          mreq.raddr = pos_r + SlotOne;
        end
      end
      lph_pkg::S_SCAN: begin
        mreq.rd    = 1'b1;
        mreq.raddr = scan_r;
      end
      lph_pkg::S_FIND: begin
        mreq.rd    = 1'b1;
        mreq.raddr = pos_r;
      end
      lph_pkg::S_PLACE: begin
        mreq.rd    = 1'b1;
        mreq.raddr = pos_r;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == lph_pkg::S_IDLE);
    out_valid = (state_r == lph_pkg::S_OUT);
    out_data  = rsp_r;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HalfLoad) else $error("entry count over half load");
  a_col_sat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(col_r) == '1 && state_r != lph_pkg::S_CLEAR |-> col_r == '1)
    else $error("collision count wrapped");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

endmodule

@@ sv/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table, 64-bit keys, linear probing, cluster repair.
// ----------------------------------------------------------------------------
//  channel | ports            | beat
//  input   | in_valid/ready   | lph_pkg::req_t
//  result  | out_valid/ready  | lph_pkg::rsp_t
// One request at a time: the beat is taken in the idle state, each probed slot
// is read through the single memory read port, and the result is handed over
// from the output state. Deletes then re-place each entry that follows in the
// cluster: it is read and cleared, and slots are probed from its home slot (its
// own slot is read again when it is home), until an empty slot ends the cluster.
// After reset a clearing pass empties the key memory before any beat is taken.
// A stalled result holds the block; no new beat is taken until it leaves.
module linear_probe_hash_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lph_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lph_pkg::rsp_t out_data
);

  lph_pkg::mem_req_t mreq;
  logic [63:0] rkey;
  logic [63:0] rval;

  lph_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .mreq, .rkey, .rval
  );

  lph_store u_store (.clk, .mreq, .rkey, .rval);

endmodule
